// ===== rtl/core/cfs_pkg.sv =====
// Shared constants, codes and control structs for the call frame stack.
package cfs_pkg;

    localparam int DEPTH     = 1024;
    localparam int SOFT_KEYS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int POS_W     = 11;
    localparam int FR_W      = 16;
    localparam int END_W     = FR_W + 1;
    localparam int SLOT_W    = 64;
    localparam int PC_W      = 32;
    localparam int ERR_W     = 32;
    localparam int KEY_W     = 8;
    localparam int OFS_W     = 10;

    typedef enum logic [2:0] {
        CMD_PUSH_ARG    = 3'd0,
        CMD_PUSH_CALL   = 3'd1,
        CMD_CALL_RET    = 3'd2,
        CMD_PUSH_GOSUB  = 3'd3,
        CMD_GOSUB_RET   = 3'd4,
        CMD_READ_LOCAL  = 3'd5,
        CMD_WRITE_LOCAL = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_OVERFLOW   = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_BAD_OFFSET = 3'd3,
        ST_BAD_FIRST  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CALL2,
        S_RD1,
        S_RD2
    } t_state;

    typedef struct packed {
        logic   latch;
        logic   finish;
        t_state step;
    } t_ctl;

    typedef struct packed {
        t_cmd op;
        logic fail;
        logic skid_full;
    } t_stat;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  read_value;
        logic [PC_W-1:0]    return_pc;
        logic [ERR_W-1:0]   restored_on_error;
        logic [KEY_W-1:0]   return_key;
        logic [POS_W-1:0]   depth;
    } t_res;

endpackage

// ===== rtl/core/cfs_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface cfs_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          command;
    logic [63:0]         value;
    logic [10:0]         first_arg;
    logic [31:0]         pc;
    logic signed [31:0]  on_error_pc;
    logic                resumable;
    logic signed [7:0]   key_index;
    logic [9:0]          offset;

    modport source (
        output valid, command, value, first_arg, pc, on_error_pc, resumable,
               key_index, offset,
        input  ready
    );
    modport sink (
        input  valid, command, value, first_arg, pc, on_error_pc, resumable,
               key_index, offset,
        output ready
    );
endinterface

interface cfs_out_if;
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [63:0]         read_value;
    logic [31:0]         return_pc;
    logic signed [31:0]  restored_on_error;
    logic signed [7:0]   return_key;
    logic [10:0]         depth;

    modport source (
        output valid, status, read_value, return_pc, restored_on_error,
               return_key, depth,
        input  ready
    );
    modport sink (
        input  valid, status, read_value, return_pc, restored_on_error,
               return_key, depth,
        output ready
    );
endinterface

// ===== rtl/core/cfs_ram.sv =====
// Generic single-port RAM with registered read data.
module cfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cfs_datapath.sv =====
// Datapath: stack pointers, slot memory, command checks and result queue.
module cfs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfs_pkg::t_ctl               i_ctl,
    output cfs_pkg::t_stat              o_stat,
    input  logic [2:0]                  i_command,
    input  logic [cfs_pkg::SLOT_W-1:0]  i_value,
    input  logic [cfs_pkg::POS_W-1:0]   i_first_arg,
    input  logic [cfs_pkg::PC_W-1:0]    i_pc,
    input  logic [cfs_pkg::ERR_W-1:0]   i_on_error_pc,
    input  logic                        i_resumable,
    input  logic [cfs_pkg::KEY_W-1:0]   i_key_index,
    input  logic [cfs_pkg::OFS_W-1:0]   i_offset,
    output cfs_pkg::t_res               o_res,
    output logic                        o_valid,
    input  logic                        i_ready
);

    localparam int POS_W  = cfs_pkg::POS_W;
    localparam int FR_W   = cfs_pkg::FR_W;
    localparam int END_W  = cfs_pkg::END_W;
    localparam int ADDR_W = cfs_pkg::ADDR_W;
    localparam int SLOT_W = cfs_pkg::SLOT_W;
    localparam int PC_W   = cfs_pkg::PC_W;
    localparam int ERR_W  = cfs_pkg::ERR_W;
    localparam int KEY_W  = cfs_pkg::KEY_W;

    // latched command fields
    logic [2:0]         r_cmd;
    logic [SLOT_W-1:0]  r_value;
    logic [POS_W-1:0]   r_first;
    logic [PC_W-1:0]    r_pc;
    logic [ERR_W-1:0]   r_onerr;
    logic               r_resum;
    logic [KEY_W-1:0]   r_key;
    logic [cfs_pkg::OFS_W-1:0] r_offset;

    // stack pointers
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [FR_W-1:0]    r_base, n_base;
    logic [FR_W-1:0]    r_len, n_len;

    // frame record held between the two call return reads
    logic [PC_W-1:0]    r_t_pc;
    logic [FR_W-1:0]    r_t_base;
    logic [FR_W-1:0]    r_t_len;

    // result queue: output register plus one skid entry
    logic               r_out_valid;
    cfs_pkg::t_res      r_out;
    logic               r_skid_valid;
    cfs_pkg::t_res      r_skid;

    logic               w_we;
    logic [ADDR_W-1:0]  w_addr;
    logic [SLOT_W-1:0]  w_wdata;
    logic [SLOT_W-1:0]  w_rdata;

    cfs_pkg::t_cmd      w_op;
    logic               w_fail;
    cfs_pkg::t_status   w_fail_st;
    cfs_pkg::t_res      w_res;

    logic [END_W-1:0]   w_end;
    logic [END_W-1:0]   w_idx;
    logic               w_full1;
    logic               w_full2;
    logic               w_bad_first;
    logic               w_no_frame;
    logic               w_no_gosub;
    logic               w_bad_off;
    logic [KEY_W-1:0]   w_key;
    logic               w_take;

    assign w_op = cfs_pkg::t_cmd'(r_cmd);

    assign w_end = {1'b0, r_base} + {1'b0, r_len};
    assign w_idx = {1'b0, r_base} + END_W'(r_offset);

    assign w_full1     = (r_pos == POS_W'(cfs_pkg::DEPTH));
    assign w_full2     = (r_pos >= POS_W'(cfs_pkg::DEPTH - 1));
    assign w_bad_first = (r_first > r_pos);
    assign w_no_frame  = (r_pos == '0) || (r_len < FR_W'(2))
                      || (w_end > END_W'(r_pos)) || (w_end > END_W'(cfs_pkg::DEPTH));
    assign w_no_gosub  = (END_W'(r_pos) <= w_end);
    assign w_bad_off   = ({1'b0, r_len} <= (END_W'(r_offset) + END_W'(2)))
                      || (w_idx >= END_W'(cfs_pkg::DEPTH));

    assign w_key = w_rdata[PC_W +: KEY_W];

    always_comb begin
        w_fail    = 1'b0;
        w_fail_st = cfs_pkg::ST_OK;
        case (w_op)
            cfs_pkg::CMD_PUSH_ARG, cfs_pkg::CMD_PUSH_GOSUB: begin
                w_fail    = w_full1;
                w_fail_st = cfs_pkg::ST_OVERFLOW;
            end
            cfs_pkg::CMD_PUSH_CALL: begin
                w_fail    = w_full2 || w_bad_first;
                w_fail_st = w_full2 ? cfs_pkg::ST_OVERFLOW : cfs_pkg::ST_BAD_FIRST;
            end
            cfs_pkg::CMD_CALL_RET: begin
                w_fail    = w_no_frame;
                w_fail_st = cfs_pkg::ST_EMPTY;
            end
            cfs_pkg::CMD_GOSUB_RET: begin
                w_fail    = w_no_gosub;
                w_fail_st = cfs_pkg::ST_EMPTY;
            end
            cfs_pkg::CMD_READ_LOCAL, cfs_pkg::CMD_WRITE_LOCAL: begin
                w_fail    = w_bad_off;
                w_fail_st = cfs_pkg::ST_BAD_OFFSET;
            end
            default: begin
                w_fail    = 1'b0;
                w_fail_st = cfs_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_base  = r_base;
        n_len   = r_len;
        w_we    = 1'b0;
        w_addr  = r_pos[ADDR_W-1:0];
        w_wdata = r_value;
        w_res.status            = cfs_pkg::ST_OK;
        w_res.read_value        = '0;
        w_res.return_pc         = '0;
        w_res.restored_on_error = '1;
        w_res.return_key        = '1;
        case (i_ctl.step)
            cfs_pkg::S_EXEC: begin
                if (w_fail) begin
                    w_res.status = w_fail_st;
                end else begin
                    case (w_op)
                        cfs_pkg::CMD_PUSH_ARG: begin
                            w_we  = 1'b1;
                            n_pos = r_pos + POS_W'(1);
                        end
                        cfs_pkg::CMD_PUSH_GOSUB: begin
                            w_we    = 1'b1;
                            w_wdata = {{(SLOT_W - PC_W - KEY_W){1'b0}}, r_key, r_pc};
                            n_pos   = r_pos + POS_W'(1);
                        end
                        cfs_pkg::CMD_PUSH_CALL: begin
                            // exception record first
                            w_we    = 1'b1;
                            w_wdata = {{(SLOT_W - ERR_W - 1){1'b0}}, r_resum, r_onerr};
                        end
                        cfs_pkg::CMD_CALL_RET: begin
                            w_addr = ADDR_W'(w_end - END_W'(1));
                        end
                        cfs_pkg::CMD_GOSUB_RET: begin
                            w_addr = ADDR_W'(r_pos - POS_W'(1));
                        end
                        cfs_pkg::CMD_READ_LOCAL: begin
                            w_addr = ADDR_W'(w_idx);
                        end
                        cfs_pkg::CMD_WRITE_LOCAL: begin
                            w_we   = 1'b1;
                            w_addr = ADDR_W'(w_idx);
                        end
                        default: begin
                            w_we = 1'b0;
                        end
                    endcase
                end
            end
            cfs_pkg::S_CALL2: begin
                // frame record, then open the new frame
                w_we    = 1'b1;
                w_addr  = ADDR_W'(r_pos + POS_W'(1));
                w_wdata = {r_len, r_base, r_pc};
                n_pos   = r_pos + POS_W'(2);
                n_base  = FR_W'(r_first);
                n_len   = FR_W'(r_pos + POS_W'(2) - r_first);
            end
            cfs_pkg::S_RD1: begin
                case (w_op)
                    cfs_pkg::CMD_CALL_RET: begin
                        w_addr = ADDR_W'(w_end - END_W'(2));
                    end
                    cfs_pkg::CMD_GOSUB_RET: begin
                        n_pos           = r_pos - POS_W'(1);
                        w_res.return_pc = w_rdata[PC_W-1:0];
                        if (!w_key[KEY_W-1]
                            && ({1'b0, w_key} < (KEY_W + 1)'(cfs_pkg::SOFT_KEYS))) begin
                            w_res.return_key = w_key;
                        end
                    end
                    cfs_pkg::CMD_READ_LOCAL: begin
                        w_res.read_value = w_rdata;
                    end
                    default: begin
                        w_we = 1'b0;
                    end
                endcase
            end
            cfs_pkg::S_RD2: begin
                n_pos                   = r_base[POS_W-1:0];
                n_base                  = r_t_base;
                n_len                   = r_t_len;
                w_res.return_pc         = r_t_pc;
                w_res.restored_on_error = w_rdata[ERR_W-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        w_res.depth = n_pos;
    end

    cfs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (cfs_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd    <= i_command;
            r_value  <= i_value;
            r_first  <= i_first_arg;
            r_pc     <= i_pc;
            r_onerr  <= i_on_error_pc;
            r_resum  <= i_resumable;
            r_key    <= i_key_index;
            r_offset <= i_offset;
        end
        if (i_ctl.step == cfs_pkg::S_RD1) begin
            r_t_pc   <= w_rdata[PC_W-1:0];
            r_t_base <= w_rdata[PC_W +: FR_W];
            r_t_len  <= w_rdata[PC_W + FR_W +: FR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_base <= '0;
            r_len  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_base <= n_base;
            r_len  <= n_len;
        end
    end

    assign w_take = r_out_valid && i_ready;

    // skid entry is only filled when the output register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= w_res;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res            = r_out;
    assign o_valid          = r_out_valid;
    assign o_stat.op        = w_op;
    assign o_stat.fail      = w_fail;
    assign o_stat.skid_full = r_skid_valid;

endmodule

// ===== rtl/core/cfs_ctrl.sv =====
// Controller: sequences one command through execute, second write and memory read steps.
module cfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfs_pkg::t_stat i_stat,
    output cfs_pkg::t_ctl  o_ctl
);

    cfs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_ctl.latch  = 1'b0;
        o_ctl.finish = 1'b0;
        o_ctl.step   = r_state;
        case (r_state)
            cfs_pkg::S_IDLE: begin
                o_ready     = !i_stat.skid_full;
                o_ctl.latch = i_valid && !i_stat.skid_full;
                if (o_ctl.latch) begin
                    n_state = cfs_pkg::S_EXEC;
                end
            end
            cfs_pkg::S_EXEC: begin
                if (i_stat.fail) begin
                    o_ctl.finish = 1'b1;
                    n_state      = cfs_pkg::S_IDLE;
                end else begin
                    case (i_stat.op)
                        cfs_pkg::CMD_PUSH_CALL: begin
                            n_state = cfs_pkg::S_CALL2;
                        end
                        cfs_pkg::CMD_CALL_RET, cfs_pkg::CMD_GOSUB_RET,
                        cfs_pkg::CMD_READ_LOCAL: begin
                            n_state = cfs_pkg::S_RD1;
                        end
                        default: begin
                            o_ctl.finish = 1'b1;
                            n_state      = cfs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            cfs_pkg::S_CALL2: begin
                o_ctl.finish = 1'b1;
                n_state      = cfs_pkg::S_IDLE;
            end
            cfs_pkg::S_RD1: begin
                if (i_stat.op == cfs_pkg::CMD_CALL_RET) begin
                    n_state = cfs_pkg::S_RD2;
                end else begin
                    o_ctl.finish = 1'b1;
                    n_state      = cfs_pkg::S_IDLE;
                end
            end
            cfs_pkg::S_RD2: begin
                o_ctl.finish = 1'b1;
                n_state      = cfs_pkg::S_IDLE;
            end
            default: begin
                n_state = cfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/call_frame_stack_top.sv =====
// Top level of the call frame stack: controller, datapath and checks.
//
//  channel   dir  handshake      payload
//  i_cmd     in   valid/ready    command, value, first_arg, pc, on_error_pc,
//                                resumable, key_index, offset
//  o_res     out  valid/ready    status, read_value, return_pc,
//                                restored_on_error, return_key, depth
//
// One command at a time. Push arg, push gosub, write local, unknown codes and
// every rejected command end in the execute step; push call adds a write step,
// gosub return and read local a read step, and call return reads the frame and
// exception records. Reset clears the pointers and the result queue; slot
// memory is not cleared. Results go through a two-entry queue, so a command is
// taken while one result is still stalled on o_res.
module call_frame_stack_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfs_in_if.sink    i_cmd,
    cfs_out_if.source o_res
);

    cfs_pkg::t_ctl  w_ctl;
    cfs_pkg::t_stat w_stat;
    cfs_pkg::t_res  w_res;
    logic           w_valid;

    cfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    cfs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .i_command     (i_cmd.command),
        .i_value       (i_cmd.value),
        .i_first_arg   (i_cmd.first_arg),
        .i_pc          (i_cmd.pc),
        .i_on_error_pc (i_cmd.on_error_pc),
        .i_resumable   (i_cmd.resumable),
        .i_key_index   (i_cmd.key_index),
        .i_offset      (i_cmd.offset),
        .o_res         (w_res),
        .o_valid       (w_valid),
        .i_ready       (o_res.ready)
    );

    assign o_res.valid             = w_valid;
    assign o_res.status            = w_res.status;
    assign o_res.read_value        = w_res.read_value;
    assign o_res.return_pc         = w_res.return_pc;
    assign o_res.restored_on_error = w_res.restored_on_error;
    assign o_res.return_key        = w_res.return_key;
    assign o_res.depth             = w_res.depth;

    // only one transaction in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while another is in flight");

    a_finish_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |-> !w_stat.skid_full)
        else $error("result finished with no room in the queue");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |=> o_res.valid)
        else $error("finished result not presented");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.depth <= 11'(cfs_pkg::DEPTH)))
        else $error("stack depth beyond capacity");

endmodule
